// ===== sv/psp_pkg.sv =====
// shared types and constants for the servo position loop
`timescale 1ns / 1ps

package psp_pkg;

  localparam int unsigned ACC_W  = 52;
  localparam int unsigned PROD_W = 51;
  localparam int unsigned RAW_W  = 36;

  localparam logic [17:0] COMPARE_OFFSET = 18'd2000;
  localparam logic [15:0] COMPARE_RESET  = 16'd3000;

  localparam logic [15:0] SET_POINT_RESET = 16'd0;
  localparam logic [15:0] GAIN_P_RESET    = 16'hEC00;
  localparam logic [15:0] GAIN_I_RESET    = 16'hFF80;
  localparam logic [15:0] GAIN_D_RESET    = 16'd0;
  localparam logic [15:0] ALPHA_RESET     = 16'd58982;

  typedef enum logic [2:0] {
    REG_SET_POINT = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_ALPHA     = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC_D,
    S_TRUNC,
    S_CLAMP,
    S_MUL_A,
    S_MUL_B,
    S_ACC_S,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_A,
    MUL_B
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic signed [15:0] set_point;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic        [15:0] alpha;
  } cfg_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     trunc_en;
    logic     clamp_en;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== sv/pid_servo_position_loop_top.sv =====
// top level of the single-axis pid servo position loop
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// in        input      in_valid / in_stall   in_angle_in (s16 q8.8)
// out       output     out_valid / out_stall out_position, out_compare_value, out_was_clamped
// cfg       input      psel/penable/pwrite   paddr[4:2] selects register, pwdata[15:0]
//
// a word is accepted while the sequencer is idle; then follow ten sequencer steps made of five
// passes through the single shared 18x33 multiplier plus accumulate, truncate, clamp
// and output steps; in_stall stays high and no new word is taken until it is back in idle.
// a finished word waits in the output register; while it is still stalled there, the
// sequencer holds the next result in its output step and keeps in_stall high.
// rst_n is synchronous; it restores the register defaults, clears the integral and the
// previous angle, and sets the smoother state to 3000.

module pid_servo_position_loop_top
  import psp_pkg::*;
#(
  parameter int unsigned POSITION_MAX = 999
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_angle_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_position,
  output logic [15:0] out_compare_value,
  output logic        out_was_clamped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  psp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  psp_dp #(
    .POSITION_MAX (POSITION_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .status            (status),
    .in_angle_in       (in_angle_in),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_position      (out_position),
    .out_compare_value (out_compare_value),
    .out_was_clamped   (out_was_clamped)
  );

endmodule

// ===== sv/psp_regs.sv =====
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module psp_regs
  import psp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_point <= SET_POINT_RESET;
      cfg_r.gain_p    <= GAIN_P_RESET;
      cfg_r.gain_i    <= GAIN_I_RESET;
      cfg_r.gain_d    <= GAIN_D_RESET;
      cfg_r.alpha     <= ALPHA_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_SET_POINT: cfg_r.set_point <= pwdata[15:0];
        REG_GAIN_P:    cfg_r.gain_p    <= pwdata[15:0];
        REG_GAIN_I:    cfg_r.gain_i    <= pwdata[15:0];
        REG_GAIN_D:    cfg_r.gain_d    <= pwdata[15:0];
        REG_ALPHA:     cfg_r.alpha     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      REG_SET_POINT: prdata = {16'd0, cfg_r.set_point};
      REG_GAIN_P:    prdata = {16'd0, cfg_r.gain_p};
      REG_GAIN_I:    prdata = {16'd0, cfg_r.gain_i};
      REG_GAIN_D:    prdata = {16'd0, cfg_r.gain_d};
      REG_ALPHA:     prdata = {16'd0, cfg_r.alpha};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/psp_ctrl.sv =====
// sequencer that steps the shared multiplier through one sample
`timescale 1ns / 1ps

module psp_ctrl
  import psp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MUL_P;
      S_MUL_P: state_nxt = S_MUL_I;
      S_MUL_I: state_nxt = S_MUL_D;
      S_MUL_D: state_nxt = S_ACC_D;
      S_ACC_D: state_nxt = S_TRUNC;
      S_TRUNC: state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_MUL_A;
      S_MUL_A: state_nxt = S_MUL_B;
      S_MUL_B: state_nxt = S_ACC_S;
      S_ACC_S: state_nxt = S_OUT;
      S_OUT:   if (!status.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_P;
    cmd.acc_op   = ACC_HOLD;
    unique case (state_r)
      S_IDLE:  cmd.load = accept;
      S_MUL_P: cmd.mul_sel = MUL_P;
      S_MUL_I: begin
        cmd.mul_sel = MUL_I;
        cmd.acc_op  = ACC_LOAD;
      end
      S_MUL_D: begin
        cmd.mul_sel = MUL_D;
        cmd.acc_op  = ACC_ADD;
      end
      // derivative term enters with a minus sign
      S_ACC_D: cmd.acc_op = ACC_SUB;
      S_TRUNC: cmd.trunc_en = 1'b1;
      S_CLAMP: cmd.clamp_en = 1'b1;
      S_MUL_A: cmd.mul_sel = MUL_A;
      S_MUL_B: begin
        cmd.mul_sel = MUL_B;
        cmd.acc_op  = ACC_LOAD;
      end
      S_ACC_S: cmd.acc_op = ACC_ADD;
      S_OUT:   cmd.out_load = !status.out_busy;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_MUL_P)
    else $error("accepted word did not start the sequence");

  a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && status.out_busy) |=> state_r == S_OUT)
    else $error("left output state while result register was occupied");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !status.out_busy)
    else $error("output load while result register was occupied");
`endif

endmodule

// ===== sv/psp_dp.sv =====
// pid datapath: error, integral, shared multiplier, clamp, smoother, output register
`timescale 1ns / 1ps

module psp_dp
  import psp_pkg::*;
#(
  parameter int unsigned POSITION_MAX = 999
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [15:0] in_angle_in,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [9:0]  out_position,
  output logic [15:0] out_compare_value,
  output logic        out_was_clamped
);

  localparam logic signed [RAW_W-1:0] POS_LIMIT = RAW_W'(POSITION_MAX);
  localparam logic [15:0] POS_MAX_16 = 16'(POSITION_MAX);

  logic signed [16:0]       err_r, deriv_r;
  logic signed [31:0]       integral_r;
  logic signed [15:0]       prev_angle_r;
  logic        [15:0]       sc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RAW_W-1:0]  raw_r;
  logic        [15:0]       pos_r;
  logic                     clamped_r;
  logic                     out_valid_r;
  logic        [9:0]        out_pos_r;
  logic        [15:0]       out_cmp_r;
  logic                     out_clamped_r;

  logic signed [16:0]       err_nxt, deriv_nxt, angle_x, sp_x, prev_x;
  logic signed [32:0]       isum;
  logic signed [31:0]       integral_nxt;
  logic signed [17:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_nxt, rnd;
  logic        [16:0]       weight_new;
  logic        [17:0]       target;
  logic        [15:0]       sc_nxt;

  assign angle_x  = {in_angle_in[15], in_angle_in};
  assign sp_x     = {cfg.set_point[15], cfg.set_point};
  assign prev_x   = {prev_angle_r[15], prev_angle_r};
  assign err_nxt   = sp_x - angle_x;
  assign deriv_nxt = angle_x - prev_x;
  assign isum      = {integral_r[31], integral_r} + {{16{err_nxt[16]}}, err_nxt};

  // saturate the integral at the signed 32 bit limits
  always_comb begin
    if (isum[32] != isum[31]) begin
      integral_nxt = isum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      integral_nxt = isum[31:0];
    end
  end

  assign weight_new = 17'h10000 - {1'b0, cfg.alpha};
  assign target     = {1'b0, pos_r, 1'b0} + COMPARE_OFFSET;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = 18'(cfg.gain_p);
        mul_b = 33'(err_r);
      end
      MUL_I: begin
        mul_a = 18'(cfg.gain_i);
        mul_b = 33'(integral_r);
      end
      MUL_D: begin
        mul_a = 18'(cfg.gain_d);
        mul_b = 33'(deriv_r);
      end
      MUL_A: begin
        mul_a = {2'b00, cfg.alpha};
        mul_b = {17'd0, sc_r};
      end
      MUL_B: begin
        mul_a = {1'b0, weight_new};
        mul_b = {15'd0, target};
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    acc_nxt = acc_r;
    case (cmd.acc_op)
      ACC_LOAD: acc_nxt = ACC_W'(prod_r);
      ACC_ADD:  acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_SUB:  acc_nxt = acc_r - ACC_W'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  assign rnd = acc_r + (acc_r[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));

  assign sc_nxt = (|acc_r[ACC_W-1:32]) ? 16'hFFFF : acc_r[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      prev_angle_r <= '0;
      sc_r         <= COMPARE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        integral_r   <= integral_nxt;
        prev_angle_r <= in_angle_in;
      end
      if (cmd.out_load) begin
        sc_r        <= sc_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cmd.load) begin
      err_r   <= err_nxt;
      deriv_r <= deriv_nxt;
    end
    if (cmd.trunc_en) begin
      raw_r <= rnd[ACC_W-1:16];
    end
    if (cmd.clamp_en) begin
      if (raw_r > POS_LIMIT) begin
        pos_r     <= POS_MAX_16;
        clamped_r <= 1'b1;
      end else if (raw_r[RAW_W-1]) begin
        pos_r     <= 16'd0;
        clamped_r <= 1'b1;
      end else begin
        pos_r     <= raw_r[15:0];
        clamped_r <= 1'b0;
      end
    end
    if (cmd.out_load) begin
      out_pos_r     <= pos_r[9:0];
      out_cmp_r     <= sc_nxt;
      out_clamped_r <= clamped_r;
    end
  end

  assign status.out_busy   = out_valid_r && out_stall;
  assign out_valid         = out_valid_r;
  assign out_position      = out_pos_r;
  assign out_compare_value = out_cmp_r;
  assign out_was_clamped   = out_clamped_r;

`ifndef ASSERT_OFF
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r && out_cmp_r == sc_r)
    else $error("loaded word not presented with the new smoother state");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clamped_r) |->
      (out_pos_r == 10'd0 || out_pos_r == POS_MAX_16[9:0]))
    else $error("clamped position is not at a limit");
`endif

endmodule
